### rtl/stream_sequence_gap_tracker_core_defines.svh
// ----------------------------------------------------------------------------
// Stream sequence gap tracker: assertion macros
// Shared macros for the concurrent checks on the tracker's ports.
// ----------------------------------------------------------------------------
`ifndef STREAM_SEQUENCE_GAP_TRACKER_CORE_DEFINES_SVH
`define STREAM_SEQUENCE_GAP_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active
`define SSGT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active
`define SSGT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ssgt_pkg.sv
// ----------------------------------------------------------------------------
// Stream sequence gap tracker package
// Widths, codes and the token and result types shared by the tracker.
// ----------------------------------------------------------------------------
package ssgt_pkg;

    localparam int MAX_STREAMS_DEF = 64;

    localparam int CMD_W   = 3;
    localparam int CH_W    = 4;
    localparam int SYM_W   = 32;
    localparam int SEQ_W   = 31;
    localparam int GEN_W   = 16;
    localparam int ACT_W   = 2;
    localparam int MASK_W  = 16;
    localparam int HOLE_W  = 32;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESUMABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAPSHOT  = 1'b1;

    localparam logic [MASK_W-1:0] RESUMABLE_RESET = 16'd96;
    localparam logic [MASK_W-1:0] SNAPSHOT_RESET  = 16'd31;

    // "No hole" encoding
    localparam logic [HOLE_W-1:0] HOLE_NONE_LOW  = 32'd1;
    localparam logic [SEQ_W-1:0]  HOLE_NONE_HIGH = 31'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_OBSERVE  = 3'd0,
        CMD_SNAPSHOT = 3'd1,
        CMD_NEW_CONN = 3'd2,
        CMD_ABANDON  = 3'd3,
        CMD_QUERY    = 3'd4
    } t_cmd;

    typedef enum logic [ACT_W-1:0] {
        ACT_PROCESS      = 2'd0,
        ACT_DROP         = 2'd1,
        ACT_RESUME       = 2'd2,
        ACT_UNREPAIRABLE = 2'd3
    } t_act;

    // Result of one transaction
    typedef struct packed {
        t_act             act;
        logic [SEQ_W-1:0] gap_first;
        logic [SEQ_W-1:0] gap_last;
        logic             found;
        logic [SEQ_W-1:0] pos;
    } t_res;

    // Search token walking the cell chain
    typedef struct packed {
        logic             vld;
        logic             done;
        logic [CMD_W-1:0] cmd;
        logic [CH_W-1:0]  ch;
        logic [SYM_W-1:0] sym;
        logic [SEQ_W-1:0] seq;
        t_res             res;
    } t_tok;

    // Block-wide settings seen by every cell
    typedef struct packed {
        logic [MASK_W-1:0] res_mask;
        logic [MASK_W-1:0] snap_mask;
        logic [GEN_W-1:0]  cur_gen;
    } t_glb;

endpackage

### rtl/ssgt_in_if.sv
// ----------------------------------------------------------------------------
// Tracker input channel
// Valid/ready channel carrying one message transaction.
// ----------------------------------------------------------------------------
interface ssgt_in_if import ssgt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [CH_W-1:0]  channel_id;
    logic [SYM_W-1:0] symbol_key;
    logic [SEQ_W-1:0] seq;

    modport source (output valid, command, channel_id, symbol_key, seq, input ready);
    modport sink   (input valid, command, channel_id, symbol_key, seq, output ready);
endinterface

### rtl/ssgt_out_if.sv
// ----------------------------------------------------------------------------
// Tracker result channel
// Valid/ready channel carrying one verdict transaction.
// ----------------------------------------------------------------------------
interface ssgt_out_if import ssgt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [SEQ_W-1:0] gap_first;
    logic [SEQ_W-1:0] gap_last;
    logic             found;
    logic [SEQ_W-1:0] position;

    modport source (output valid, action, gap_first, gap_last, found, position,
                    input ready);
    modport sink   (input valid, action, gap_first, gap_last, found, position,
                    output ready);
endinterface

### rtl/ssgt_cell.sv
// ----------------------------------------------------------------------------
// Tracker table cell
// Holds one stream entry, checks the passing token against it, applies the
// update on a hit or an allocation and hands the token to the next cell.
// ----------------------------------------------------------------------------
module ssgt_cell import ssgt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_glb i_glb,
    input  t_tok i_tok,
    output t_tok o_tok
);

    logic              r_valid, n_valid;
    logic [CH_W-1:0]   r_ch, n_ch;
    logic [SYM_W-1:0]  r_sym, n_sym;
    logic [SEQ_W-1:0]  r_seq, n_seq;
    logic [GEN_W-1:0]  r_gen, n_gen;
    logic [HOLE_W-1:0] r_hl, n_hl;
    logic [SEQ_W-1:0]  r_hh, n_hh;
    t_tok              r_tok, n_tok;

    // Entry update and token hand-off
    always_comb begin
        logic              hit;
        logic              is_obs;
        logic [HOLE_W-1:0] seq_x;
        logic [HOLE_W-1:0] prev_p1;
        logic              seq_le;
        logic              in_hole;
        n_valid = r_valid;
        n_ch    = r_ch;
        n_sym   = r_sym;
        n_seq   = r_seq;
        n_gen   = r_gen;
        n_hl    = r_hl;
        n_hh    = r_hh;
        n_tok   = i_tok;
        hit     = r_valid && (r_ch == i_tok.ch) && (r_sym == i_tok.sym);
        is_obs  = (i_tok.cmd == CMD_OBSERVE) || (i_tok.cmd == CMD_SNAPSHOT);
        seq_x   = {1'b0, i_tok.seq};
        prev_p1 = {1'b0, r_seq} + 32'd1;
        seq_le  = i_tok.seq <= r_seq;
        in_hole = (seq_x >= r_hl) && (i_tok.seq <= r_hh);

        if (i_tok.vld && !i_tok.done) begin
            if (!r_valid) begin
                // first free cell: new stream takes it
                if (is_obs) begin
                    n_valid    = 1'b1;
                    n_ch       = i_tok.ch;
                    n_sym      = i_tok.sym;
                    n_seq      = i_tok.seq;
                    n_gen      = i_glb.cur_gen;
                    n_hl       = HOLE_NONE_LOW;
                    n_hh       = HOLE_NONE_HIGH;
                    n_tok.done = 1'b1;
                end
            end else if (hit) begin
                n_tok.done = 1'b1;
                case (i_tok.cmd)
                    CMD_OBSERVE, CMD_SNAPSHOT: begin
                        if (i_tok.cmd == CMD_SNAPSHOT ||
                            (seq_le && r_gen != i_glb.cur_gen)) begin
                            // re-baseline
                            n_seq = i_tok.seq;
                            n_gen = i_glb.cur_gen;
                            n_hl  = HOLE_NONE_LOW;
                            n_hh  = HOLE_NONE_HIGH;
                        end else if (seq_le) begin
                            if (in_hole) begin
                                n_hl = seq_x + 32'd1;
                            end else begin
                                n_tok.res.act = ACT_DROP;
                            end
                        end else begin
                            // forward move
                            n_seq = i_tok.seq;
                            n_gen = i_glb.cur_gen;
                            if (seq_x != prev_p1) begin
                                if (i_glb.res_mask[i_tok.ch]) begin
                                    n_hl                = prev_p1;
                                    n_hh                = i_tok.seq - 31'd1;
                                    n_tok.res.act       = ACT_RESUME;
                                    n_tok.res.gap_first = prev_p1[SEQ_W-1:0];
                                    n_tok.res.gap_last  = i_tok.seq - 31'd1;
                                end else if (!i_glb.snap_mask[i_tok.ch]) begin
                                    n_tok.res.act       = ACT_UNREPAIRABLE;
                                    n_tok.res.gap_first = prev_p1[SEQ_W-1:0];
                                    n_tok.res.gap_last  = i_tok.seq - 31'd1;
                                end
                            end
                        end
                    end
                    CMD_ABANDON: begin
                        n_hl = HOLE_NONE_LOW;
                        n_hh = HOLE_NONE_HIGH;
                    end
                    CMD_QUERY: begin
                        n_tok.res.found = 1'b1;
                        n_tok.res.pos   = r_seq;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Entry and token registers; only the valid bits take reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_tok.vld <= n_tok.vld;
        end
        r_ch       <= n_ch;
        r_sym      <= n_sym;
        r_seq      <= n_seq;
        r_gen      <= n_gen;
        r_hl       <= n_hl;
        r_hh       <= n_hh;
        r_tok.done <= n_tok.done;
        r_tok.cmd  <= n_tok.cmd;
        r_tok.ch   <= n_tok.ch;
        r_tok.sym  <= n_tok.sym;
        r_tok.seq  <= n_tok.seq;
        r_tok.res  <= n_tok.res;
    end

    assign o_tok = r_tok;

endmodule

### rtl/ssgt_res_buf.sv
// ----------------------------------------------------------------------------
// Tracker result buffer
// Two-entry queue between the cell chain and the result channel.
// ----------------------------------------------------------------------------
module ssgt_res_buf import ssgt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_res        i_data,
    output logic        o_full,
    ssgt_out_if.source  o_out
);

    t_res       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign pop = o_out.valid && o_out.ready;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ pop;
        n_cnt    = r_cnt + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Head entry drives the channel
    assign o_full          = r_cnt == 2'd2;
    assign o_out.valid     = r_cnt != 2'd0;
    assign o_out.action    = r_mem[r_rd_ptr].act;
    assign o_out.gap_first = r_mem[r_rd_ptr].gap_first;
    assign o_out.gap_last  = r_mem[r_rd_ptr].gap_last;
    assign o_out.found     = r_mem[r_rd_ptr].found;
    assign o_out.position  = r_mem[r_rd_ptr].pos;

endmodule

### rtl/stream_sequence_gap_tracker_core.sv
// Each transaction's token passes through every cell's register before its result enters the buffer.
// The search token walks the cell chain one cell per cycle, one token in flight; a new
//   transaction is taken only after the previous token has left the chain.
// Results queue in a two-entry buffer, so input is taken while one result waits.
// Reset (synchronous, active low) empties the table, sets the masks to 96 and
//   31 and the generation to zero.
// ----------------------------------------------------------------------------
// Stream sequence gap tracker
// Per-stream sequence tracking over a chain of entry cells with gap verdicts.
// ----------------------------------------------------------------------------
module stream_sequence_gap_tracker_core import ssgt_pkg::*; #(
    parameter int MAX_STREAMS = MAX_STREAMS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [MASK_W-1:0]    i_cfg_data,
    ssgt_in_if.sink              i_in,
    ssgt_out_if.source           o_out
);

    logic [MASK_W-1:0] r_res_mask, n_res_mask;
    logic [MASK_W-1:0] r_snap_mask, n_snap_mask;
    logic [GEN_W-1:0]  r_gen, n_gen;
    logic              r_busy, n_busy;
    logic              accept;
    logic              buf_full;
    t_glb              glb;
    t_tok              chain [0:MAX_STREAMS];

    assign i_in.ready = !r_busy && !buf_full;
    assign accept     = i_in.valid && i_in.ready;

    // Configuration, generation and in-flight tracking
    always_comb begin
        n_res_mask  = r_res_mask;
        n_snap_mask = r_snap_mask;
        n_gen       = r_gen;
        n_busy      = r_busy;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RESUMABLE: n_res_mask  = i_cfg_data;
                CFG_SNAPSHOT:  n_snap_mask = i_cfg_data;
                default: begin
                end
            endcase
        end
        if (accept && i_in.command == CMD_NEW_CONN) begin
            n_gen = r_gen + 16'd1;
        end
        if (accept) begin
            n_busy = 1'b1;
        end else if (chain[MAX_STREAMS].vld) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_mask  <= RESUMABLE_RESET;
            r_snap_mask <= SNAPSHOT_RESET;
            r_gen       <= '0;
            r_busy      <= 1'b0;
        end else begin
            r_res_mask  <= n_res_mask;
            r_snap_mask <= n_snap_mask;
            r_gen       <= n_gen;
            r_busy      <= n_busy;
        end
    end

    assign glb.res_mask  = r_res_mask;
    assign glb.snap_mask = r_snap_mask;
    assign glb.cur_gen   = r_gen;

    // Token injection: commands needing no table walk finish here
    always_comb begin
        chain[0].vld  = accept;
        chain[0].cmd  = i_in.command;
        chain[0].ch   = i_in.channel_id;
        chain[0].sym  = i_in.symbol_key;
        chain[0].seq  = i_in.seq;
        chain[0].res  = '{act: ACT_PROCESS, gap_first: '0, gap_last: '0,
                          found: 1'b0, pos: '0};
        case (i_in.command)
            CMD_OBSERVE, CMD_SNAPSHOT: chain[0].done = i_in.seq == '0;
            CMD_ABANDON, CMD_QUERY:    chain[0].done = 1'b0;
            default:                   chain[0].done = 1'b1;
        endcase
    end

    // Cell chain
    for (genvar g = 0; g < MAX_STREAMS; g++) begin : g_cell
        ssgt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_glb   (glb),
            .i_tok   (chain[g]),
            .o_tok   (chain[g+1])
        );
    end

    // Result queue
    ssgt_res_buf u_res_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (chain[MAX_STREAMS].vld),
        .i_data  (chain[MAX_STREAMS].res),
        .o_full  (buf_full),
        .o_out   (o_out)
    );

endmodule

### rtl/ssgt_checker.sv
// ----------------------------------------------------------------------------
// Stream sequence gap tracker checker
// Port-level checks on handshake and verdict consistency, bound to the core.
// ----------------------------------------------------------------------------
`include "stream_sequence_gap_tracker_core_defines.svh"

module ssgt_checker import ssgt_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [ACT_W-1:0] i_action,
    input logic [SEQ_W-1:0] i_gap_first,
    input logic [SEQ_W-1:0] i_gap_last,
    input logic             i_found
);

    logic is_gap;

    assign is_gap = (i_action == ACT_RESUME) || (i_action == ACT_UNREPAIRABLE);

    // A stalled result stays offered
    `SSGT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // One transaction in flight: input closes right after a transaction
    `SSGT_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input ready while a token walks the chain")

    // Reported gaps are ordered
    `SSGT_ASSERT_IMPL(a_gap_order, i_clk, i_rst_n, i_out_valid && is_gap, i_gap_first <= i_gap_last, "gap range reversed")

    // Gap fields are zero unless a gap is reported
    `SSGT_ASSERT_IMPL(a_gap_zero, i_clk, i_rst_n, i_out_valid && !is_gap, i_gap_first == '0 && i_gap_last == '0, "gap fields set without a gap verdict")

    // A query hit is always a plain process verdict
    `SSGT_ASSERT_IMPL(a_found_process, i_clk, i_rst_n, i_out_valid && i_found, i_action == ACT_PROCESS, "found set on a non-process verdict")

endmodule

bind stream_sequence_gap_tracker_core ssgt_checker u_ssgt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_action    (o_out.action),
    .i_gap_first (o_out.gap_first),
    .i_gap_last  (o_out.gap_last),
    .i_found     (o_out.found)
);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream sequence gap tracker testbench
// Drives message transactions through the tracker and checks every verdict
// against a cycle-free model of the stream table. A short directed run covers
// the edge cases. Random phases under several channel mask settings follow.
// The random traffic is mostly in-order streams with jumps, backfills,
// snapshots and reconnects, plus some noise.
// ----------------------------------------------------------------------------
module tb;
    import ssgt_pkg::*;

    localparam logic [SEQ_W-1:0] SEQ_MAX  = 31'h7FFF_FFFF;
    localparam logic [CMD_W-1:0] CMD_RSVD = 3'd7;
    localparam int NKEYS           = 60;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [CH_W-1:0]  ch;
        logic [SYM_W-1:0] sym;
        logic [SEQ_W-1:0] seq;
    } t_msg;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [MASK_W-1:0] cfg_data;

    ssgt_in_if  in_if();
    ssgt_out_if out_if();

    stream_sequence_gap_tracker_core #(
        .MAX_STREAMS(MAX_STREAMS_DEF)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Clock: 20 ns period
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Model of the stream table
    logic [MASK_W-1:0] res_mask;
    logic [MASK_W-1:0] snap_mask;
    logic [GEN_W-1:0]  cur_gen = '0;
    int                trk_count = 0;
    logic [CH_W-1:0]   trk_ch   [MAX_STREAMS_DEF];
    logic [SYM_W-1:0]  trk_sym  [MAX_STREAMS_DEF];
    logic [SEQ_W-1:0]  trk_seq  [MAX_STREAMS_DEF];
    logic [GEN_W-1:0]  trk_gen  [MAX_STREAMS_DEF];
    logic [HOLE_W-1:0] hole_lo  [MAX_STREAMS_DEF];
    logic [SEQ_W-1:0]  hole_hi  [MAX_STREAMS_DEF];

    // Stimulus-side view of each stream in the key pool
    logic [CH_W-1:0]   pool_ch   [NKEYS];
    logic [SYM_W-1:0]  pool_sym  [NKEYS];
    logic [SEQ_W-1:0]  pool_last [NKEYS];

    t_msg msg_q[$];
    t_res verdict_q[$];

    bit idle_on;
    int n_sent;
    int n_in_acc;
    int src_gap;
    int snk_gap;
    int err_cnt;
    int n_pushed;
    int n_checked;
    int n_resume;
    int n_unrep;
    int n_drop;
    int n_found;
    int stall_cnt;

    function automatic int lookup_entry(input logic [CH_W-1:0] ch, input logic [SYM_W-1:0] sym);
        for (int i = 0; i < trk_count; i++)
            if (trk_ch[i] == ch && trk_sym[i] == sym)
                return i;
        return -1;
    endfunction

    function automatic void rebase_stream(input int idx, input logic [SEQ_W-1:0] seq);
        trk_seq[idx] = seq;
        trk_gen[idx] = cur_gen;
        hole_lo[idx] = HOLE_NONE_LOW;
        hole_hi[idx] = HOLE_NONE_HIGH;
    endfunction

    // Expected verdict of one message; updates the table model
    function automatic t_res track_message(input t_msg m);
        t_res             r;
        int               idx;
        logic [SEQ_W-1:0] prev;
        r = '0;
        if (m.cmd == CMD_OBSERVE || m.cmd == CMD_SNAPSHOT) begin
            if (m.seq != '0) begin
                idx = lookup_entry(m.ch, m.sym);
                if (idx < 0) begin
                    // new stream, tracked only while there is room
                    if (trk_count < MAX_STREAMS_DEF) begin
                        trk_ch[trk_count]  = m.ch;
                        trk_sym[trk_count] = m.sym;
                        rebase_stream(trk_count, m.seq);
                        trk_count++;
                    end
                end else if (m.cmd == CMD_SNAPSHOT) begin
                    rebase_stream(idx, m.seq);
                end else if (m.seq <= trk_seq[idx]) begin
                    if (trk_gen[idx] != cur_gen) begin
                        rebase_stream(idx, m.seq);
                    end else if ({1'b0, m.seq} >= hole_lo[idx] && m.seq <= hole_hi[idx]) begin
                        hole_lo[idx] = {1'b0, m.seq} + 32'd1;
                    end else begin
                        r.act = ACT_DROP;
                    end
                end else begin
                    prev         = trk_seq[idx];
                    trk_seq[idx] = m.seq;
                    trk_gen[idx] = cur_gen;
                    if ({1'b0, m.seq} != {1'b0, prev} + 32'd1) begin
                        if (res_mask[m.ch]) begin
                            hole_lo[idx] = {1'b0, prev} + 32'd1;
                            hole_hi[idx] = m.seq - 31'd1;
                            r.act        = ACT_RESUME;
                            r.gap_first  = prev + 31'd1;
                            r.gap_last   = m.seq - 31'd1;
                        end else if (!snap_mask[m.ch]) begin
                            r.act       = ACT_UNREPAIRABLE;
                            r.gap_first = prev + 31'd1;
                            r.gap_last  = m.seq - 31'd1;
                        end
                    end
                end
            end
        end else if (m.cmd == CMD_NEW_CONN) begin
            cur_gen = cur_gen + 16'd1;
        end else if (m.cmd == CMD_ABANDON) begin
            idx = lookup_entry(m.ch, m.sym);
            if (idx >= 0) begin
                hole_lo[idx] = HOLE_NONE_LOW;
                hole_hi[idx] = HOLE_NONE_HIGH;
            end
        end else if (m.cmd == CMD_QUERY) begin
            idx = lookup_entry(m.ch, m.sym);
            if (idx >= 0) begin
                r.found = 1'b1;
                r.pos   = trk_seq[idx];
            end
        end
        return r;
    endfunction

    // Random message, mostly well-formed traffic on pooled streams
    function automatic t_msg random_msg();
        t_msg             m;
        int               k;
        int               pick;
        logic [31:0]      t;
        logic [SEQ_W-1:0] s;
        k     = $urandom_range(0, NKEYS - 1);
        pick  = $urandom_range(0, 99);
        m.cmd = CMD_OBSERVE;
        m.ch  = pool_ch[k];
        m.sym = pool_sym[k];
        s     = pool_last[k];
        if (pick < 50) begin
            // next in order
            if (s != SEQ_MAX)
                s = s + 31'd1;
            pool_last[k] = s;
        end else if (pick < 62) begin
            // jump forward
            t = {1'b0, s} + $urandom_range(2, 40);
            if (t > {1'b0, SEQ_MAX})
                t = {1'b0, SEQ_MAX};
            s = t[SEQ_W-1:0];
            pool_last[k] = s;
        end else if (pick < 72) begin
            // backfill or stale number
            t = $urandom_range(1, 40);
            s = ({1'b0, s} > t) ? s - t[SEQ_W-1:0] : 31'd1;
        end else if (pick < 77) begin
            m.cmd = CMD_SNAPSHOT;
            s = SEQ_W'($urandom_range(0, 1) ? ($urandom & SEQ_MAX)
                                            : $urandom_range(1, 5000));
            if (s == '0)
                s = 31'd1;
            pool_last[k] = s;
        end else if (pick < 81) begin
            // reconnect: some streams restart their numbering low
            m.cmd = CMD_NEW_CONN;
            m.ch  = CH_W'($urandom_range(0, 15));
            m.sym = $urandom;
            s     = SEQ_W'($urandom);
            for (int j = 0; j < 4; j++)
                pool_last[$urandom_range(0, NKEYS - 1)] = SEQ_W'($urandom_range(1, 20));
        end else if (pick < 85) begin
            m.cmd = CMD_ABANDON;
            s     = SEQ_W'($urandom);
        end else if (pick < 93) begin
            m.cmd = CMD_QUERY;
            s     = SEQ_W'($urandom);
        end else if (pick < 96) begin
            m.cmd = $urandom_range(0, 1) ? CMD_SNAPSHOT : CMD_OBSERVE;
            s     = '0;
        end else begin
            // noise: any command, fresh keys
            m.cmd = CMD_W'($urandom_range(0, 7));
            m.ch  = CH_W'($urandom_range(0, 15));
            m.sym = $urandom;
            s     = SEQ_W'($urandom);
        end
        m.seq = s;
        return m;
    endfunction

    task automatic push_msg(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
                            input logic [SYM_W-1:0] sym, input logic [SEQ_W-1:0] seq);
        msg_q.push_back('{cmd: cmd, ch: ch, sym: sym, seq: seq});
        n_pushed++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        if (idx == CFG_RESUMABLE)
            res_mask = val;
        else
            snap_mask = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // Hold off until every pushed message has its verdict checked
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (n_checked != n_pushed);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Driver: source and sink sides change at the falling edge
    always @(negedge i_clk) begin : drive_proc
        t_msg m;
        if (!i_rst_n) begin
            in_if.valid      <= 1'b0;
            in_if.command    <= CMD_OBSERVE;
            in_if.channel_id <= '0;
            in_if.symbol_key <= '0;
            in_if.seq        <= '0;
            out_if.ready     <= 1'b0;
        end else begin
            // the offered transaction, if any, has been taken
            if (n_in_acc == n_sent) begin
                if (src_gap != 0) begin
                    src_gap--;
                    in_if.valid <= 1'b0;
                end else if (msg_q.size() != 0) begin
                    m = msg_q.pop_front();
                    n_sent++;
                    in_if.valid      <= 1'b1;
                    in_if.command    <= m.cmd;
                    in_if.channel_id <= m.ch;
                    in_if.symbol_key <= m.sym;
                    in_if.seq        <= m.seq;
                    if (idle_on && $urandom_range(0, 9) == 0)
                        src_gap = $urandom_range(1, 16);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            if (snk_gap != 0) begin
                snk_gap--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 11) == 0)
                    snk_gap = $urandom_range(1, 16);
            end
        end
    end

    // Monitor: verdict check, prediction and watchdog at the rising edge
    always @(posedge i_clk) begin : check_proc
        t_res want;
        t_msg m;
        bit   moved;
        if (i_rst_n) begin
            moved = 1'b0;
            // check the result first: it belongs to an older transaction
            if (out_if.valid && out_if.ready) begin
                moved = 1'b1;
                if (verdict_q.size() == 0) begin
                    $error("result transaction with no verdict pending");
                    err_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    n_checked++;
                    check_field("action",    32'(want.act),       32'(out_if.action));
                    check_field("gap_first", 32'(want.gap_first), 32'(out_if.gap_first));
                    check_field("gap_last",  32'(want.gap_last),  32'(out_if.gap_last));
                    check_field("found",     32'(want.found),     32'(out_if.found));
                    check_field("position",  32'(want.pos),       32'(out_if.position));
                end
            end
            if (in_if.valid && in_if.ready) begin
                moved = 1'b1;
                n_in_acc++;
                m.cmd = in_if.command;
                m.ch  = in_if.channel_id;
                m.sym = in_if.symbol_key;
                m.seq = in_if.seq;
                want  = track_message(m);
                verdict_q.push_back(want);
                case (want.act)
                    ACT_RESUME:       n_resume++;
                    ACT_UNREPAIRABLE: n_unrep++;
                    ACT_DROP:         n_drop++;
                    default: ;
                endcase
                if (want.found)
                    n_found++;
            end
            if (moved) begin
                stall_cnt = 0;
            end else begin
                stall_cnt++;
                if (stall_cnt >= WATCHDOG_LIMIT) begin
                    $error("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    // Stimulus and run control
    initial begin : stim_proc
        logic [MASK_W-1:0] rm;
        logic [MASK_W-1:0] sm;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_RESUMABLE;
        cfg_data  = '0;
        i_rst_n   = 1'b0;
        idle_on   = 1'b1;
        res_mask  = RESUMABLE_RESET;
        snap_mask = SNAPSHOT_RESET;
        for (int k = 0; k < NKEYS; k++) begin
            pool_ch[k]   = CH_W'($urandom_range(0, 15));
            pool_sym[k]  = (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF : $urandom;
            pool_last[k] = SEQ_W'((k % 8 == 7) ? SEQ_MAX - $urandom_range(0, 60)
                                               : $urandom_range(1, 1000));
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part under reset masks: ch 5,6 resumable, ch 0-4 snapshot
        push_msg(CMD_OBSERVE,  4'd0,  32'h0, 31'd0);        // invalid sequence
        push_msg(CMD_OBSERVE,  4'd5,  32'h0, 31'd1);        // first message adds stream
        push_msg(CMD_OBSERVE,  4'd5,  32'h0, 31'd2);
        push_msg(CMD_OBSERVE,  4'd5,  32'h0, 31'd10);       // jump opens a hole
        push_msg(CMD_OBSERVE,  4'd5,  32'h0, 31'd4);        // backfill inside the hole
        push_msg(CMD_OBSERVE,  4'd5,  32'h0, 31'd3);        // below the hole: drop
        push_msg(CMD_ABANDON,  4'd5,  32'h0, 31'd0);
        push_msg(CMD_OBSERVE,  4'd5,  32'h0, 31'd6);        // hole gone: drop
        push_msg(CMD_QUERY,    4'd5,  32'h0, 31'd0);
        push_msg(CMD_QUERY,    4'd9,  32'd1234, 31'd0);     // untracked query
        push_msg(CMD_ABANDON,  4'd9,  32'd1234, 31'd0);     // untracked abandon
        push_msg(CMD_OBSERVE,  4'd0,  32'hFFFF_FFFF, SEQ_MAX - 31'd15);
        push_msg(CMD_OBSERVE,  4'd0,  32'hFFFF_FFFF, SEQ_MAX); // snapshot channel jump
        push_msg(CMD_OBSERVE,  4'd15, 32'hFFFF_FFFF, 31'd100);
        push_msg(CMD_OBSERVE,  4'd15, 32'hFFFF_FFFF, 31'd200); // unrepairable
        push_msg(CMD_SNAPSHOT, 4'd15, 32'hFFFF_FFFF, 31'd50);  // re-baseline
        push_msg(CMD_OBSERVE,  4'd15, 32'hFFFF_FFFF, 31'd50);  // duplicate: drop
        push_msg(CMD_NEW_CONN, 4'd15, 32'hFFFF_FFFF, SEQ_MAX);
        push_msg(CMD_OBSERVE,  4'd15, 32'hFFFF_FFFF, 31'd20);  // older generation adopts
        push_msg(CMD_QUERY,    4'd15, 32'hFFFF_FFFF, 31'd0);
        push_msg(CMD_RSVD,     4'd15, 32'hFFFF_FFFF, SEQ_MAX); // undefined command
        push_msg(CMD_OBSERVE,  4'd15, 32'hFFFF_FFFF, SEQ_MAX); // widest gap
        push_msg(CMD_SNAPSHOT, 4'd15, 32'hFFFF_FFFF, 31'd0);   // snapshot, invalid seq
        push_msg(CMD_SNAPSHOT, 4'd6,  32'h5A5A_A5A5, 31'd7);   // snapshot on new stream

        // Random phases; each starts from an idle block with new masks
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin rm = 16'hFFFF; sm = 16'h0000; end
                1: begin rm = 16'h0000; sm = 16'hFFFF; end
                2: begin rm = 16'h0000; sm = 16'h0000; end
                3: begin rm = 16'hFFFF; sm = 16'hFFFF; end
                default: begin rm = MASK_W'($urandom); sm = MASK_W'($urandom); end
            endcase
            write_reg(CFG_RESUMABLE, rm);
            write_reg(CFG_SNAPSHOT, sm);
            if (ph == N_PHASES - 1)
                idle_on = 1'b0;
            repeat (ITEMS_PER_PHASE) begin
                msg_q.push_back(random_msg());
                n_pushed++;
            end
        end

        wait_idle();
        repeat (MAX_STREAMS_DEF + 16) @(posedge i_clk);
        if (verdict_q.size() != 0)
            $error("%0d verdicts never arrived", verdict_q.size());
        $display("Ran %0d messages over %0d mask settings; table holds %0d streams",
                 n_pushed, N_PHASES + 1, trk_count);
        $display("Verdicts seen: %0d resume, %0d unrepairable, %0d drop, %0d found queries",
                 n_resume, n_unrep, n_drop, n_found);
        if (err_cnt == 0 && verdict_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
